// ===== rtl/mkdr_pkg.sv =====
`default_nettype none

package mkdr_pkg;

    localparam int KEY_W       = 16;
    localparam int KEY_IDX_W   = 4;
    localparam int CODE_W      = 7;
    localparam int CFG_W       = 10;
    localparam int CFG_INDEX_W = 4;
    localparam int ACCUM_W     = 11;

    localparam logic [CFG_W-1:0]   TICK_PERIOD_RESET = CFG_W'(10);
    localparam logic [CFG_W-1:0]   DEBOUNCE_RESET    = CFG_W'(40);
    localparam logic [ACCUM_W-1:0] ACCUM_MAX         = {ACCUM_W{1'b1}};
    localparam logic [CODE_W-1:0]  NO_KEY            = '0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TICK_PERIOD = 4'd0,
        REG_DEBOUNCE    = 4'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_SCANNING = 2'd0,
        ST_DEBOUNCE = 2'd1,
        ST_HOLD     = 2'd2
    } scan_state_t;

    typedef logic [CODE_W-1:0] key_code_t;

    localparam key_code_t KEY_CODES [KEY_W] = '{
        key_code_t'("1"), key_code_t'("2"), key_code_t'("3"), key_code_t'("A"),
        key_code_t'("4"), key_code_t'("5"), key_code_t'("6"), key_code_t'("B"),
        key_code_t'("7"), key_code_t'("8"), key_code_t'("9"), key_code_t'("C"),
        key_code_t'("*"), key_code_t'("0"), key_code_t'("#"), key_code_t'("D")
    };

endpackage

`default_nettype wire

// ===== rtl/mkdr_key_if.sv =====
`default_nettype none

interface mkdr_key_if import mkdr_pkg::*;;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_matrix;

    modport source (output valid, output key_matrix, input ready);
    modport sink (input valid, input key_matrix, output ready);
endinterface

`default_nettype wire

// ===== rtl/mkdr_rel_if.sv =====
`default_nettype none

interface mkdr_rel_if import mkdr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] released_key;

    modport source (output valid, output released_key, input ready);
    modport sink (input valid, input released_key, output ready);
endinterface

`default_nettype wire

// ===== rtl/mkdr_cfg_if.sv =====
`default_nettype none

interface mkdr_cfg_if import mkdr_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mkdr_scan.sv =====
`default_nettype none

module mkdr_scan import mkdr_pkg::*;
(
    input  wire logic [KEY_W-1:0] key_matrix,
    output key_code_t             key_code
);

    logic [KEY_IDX_W-1:0] first_idx;
    logic                 any_key;

    always_comb
    begin
        first_idx = '0;
        for (int i = KEY_W - 1; i >= 0; i--)
        begin
            if (key_matrix[i])
            begin
                first_idx = KEY_IDX_W'(i);
            end
        end
    end

    assign any_key  = |key_matrix;
    assign key_code = any_key ? KEY_CODES[first_idx] : NO_KEY;

endmodule

`default_nettype wire

// ===== rtl/matrix_keypad_debounce_release.sv =====
// 4x4 keypad debounce and release detector. Each transfer on key_in is one
// tick carrying a snapshot of the 16 keys; each tick yields exactly one
// transfer on rel_out, the released key's ASCII code or 0. One tick is
// accepted every clock cycle while rel_out is not stalled. The scan, compare and
// accumulate run in a single pass from the input register to the result
// register, which drives rel_out. While rel_out stalls, the result holds and
// key_in takes one more tick before it stalls too.
// Registers tick_period_ms (index 0) and debounce_ms (index 1) are written
// through cfg, which is always ready; other indexes are ignored.
`default_nettype none

module matrix_keypad_debounce_release import mkdr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    mkdr_key_if.sink    key_in,
    mkdr_rel_if.source  rel_out,
    mkdr_cfg_if.sink    cfg
);

    logic               in_valid_reg;
    logic [KEY_W-1:0]   matrix_reg;
    logic               out_valid_reg;
    key_code_t          released_reg;
    scan_state_t        state_reg;
    scan_state_t        state_next;
    key_code_t          held_key_reg;
    key_code_t          held_key_next;
    logic [ACCUM_W-1:0] accum_reg;
    logic [ACCUM_W-1:0] accum_next;
    logic [CFG_W-1:0]   tick_period_reg;
    logic [CFG_W-1:0]   debounce_reg;
    key_code_t          released_next;
    key_code_t          scan_key;
    logic [ACCUM_W:0]   accum_sum;
    logic               advance;

    mkdr_scan u_scan
    (
        .key_matrix (matrix_reg),
        .key_code   (scan_key)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || rel_out.ready);
    assign key_in.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    assign rel_out.valid        = out_valid_reg;
    assign rel_out.released_key = released_reg;

    assign accum_sum = {1'b0, accum_reg} + (ACCUM_W + 1)'(tick_period_reg);

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_PERIOD_RESET;
            debounce_reg    <= DEBOUNCE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TICK_PERIOD: tick_period_reg <= cfg.data;
                REG_DEBOUNCE:    debounce_reg    <= cfg.data;
                default:         ;
            endcase
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (key_in.ready)
            begin
                in_valid_reg <= key_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rel_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (key_in.valid && key_in.ready)
        begin
            matrix_reg <= key_in.key_matrix;
        end
        if (advance)
        begin
            released_reg <= released_next;
        end
    end

    // state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SCANNING;
            held_key_reg <= NO_KEY;
            accum_reg    <= '0;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            held_key_reg <= held_key_next;
            accum_reg    <= accum_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        held_key_next = held_key_reg;
        accum_next    = accum_reg;
        released_next = NO_KEY;
        case (state_reg)
            ST_SCANNING:
            begin
                if (scan_key != NO_KEY)
                begin
                    held_key_next = scan_key;
                    accum_next    = '0;
                    state_next    = ST_DEBOUNCE;
                end
            end
            ST_DEBOUNCE:
            begin
                if (accum_reg >= ACCUM_W'(debounce_reg))
                begin
                    state_next = (scan_key == held_key_reg) ? ST_HOLD : ST_SCANNING;
                end
                else
                begin
                    accum_next = accum_sum[ACCUM_W] ? ACCUM_MAX : accum_sum[ACCUM_W-1:0];
                end
            end
            ST_HOLD:
            begin
                if (scan_key != held_key_reg)
                begin
                    released_next = held_key_reg;
                    state_next    = ST_SCANNING;
                end
            end
            default:
            begin
                state_next = ST_SCANNING;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mkdr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd9;

    logic clk;
    logic rst_n;

    mkdr_key_if key_bus ();
    mkdr_rel_if rel_bus ();
    mkdr_cfg_if cfg_bus ();

    matrix_keypad_debounce_release dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key_bus),
        .rel_out (rel_bus),
        .cfg     (cfg_bus)
    );

    scan_state_t        model_state;
    key_code_t          model_held;
    logic [ACCUM_W-1:0] model_accum;
    logic [CFG_W-1:0]   model_tick_ms;
    logic [CFG_W-1:0]   model_debounce_ms;

    key_code_t pending_releases[$];
    int        mismatches;
    int        ticks_sent;
    int        cycle_count;
    bit        idle_on;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_releases.size());
            $display("matrix_keypad_debounce_release verification failed");
            $finish;
        end
    end

    function automatic key_code_t first_pressed(input logic [KEY_W-1:0] keys);
        key_code_t code;
        code = NO_KEY;
        for (int i = KEY_W - 1; i >= 0; i--)
        begin
            if (keys[i])
                code = KEY_CODES[i];
        end
        return code;
    endfunction

    function automatic key_code_t advance_keypad(input logic [KEY_W-1:0] keys);
        key_code_t        code;
        key_code_t        released;
        logic [ACCUM_W:0] sum;
        released = NO_KEY;
        code = first_pressed(keys);
        case (model_state)
            ST_SCANNING:
            begin
                if (code != NO_KEY)
                begin
                    model_held = code;
                    model_accum = '0;
                    model_state = ST_DEBOUNCE;
                end
            end
            ST_DEBOUNCE:
            begin
                if (model_accum >= ACCUM_W'(model_debounce_ms))
                begin
                    model_state = (code == model_held) ? ST_HOLD : ST_SCANNING;
                end
                else
                begin
                    sum = {1'b0, model_accum} + (ACCUM_W + 1)'(model_tick_ms);
                    model_accum = (sum > {1'b0, ACCUM_MAX}) ? ACCUM_MAX : sum[ACCUM_W-1:0];
                end
            end
            ST_HOLD:
            begin
                if (code != model_held)
                begin
                    released = model_held;
                    model_state = ST_SCANNING;
                end
            end
            default: model_state = ST_SCANNING;
        endcase
        return released;
    endfunction

    function automatic int ticks_to_hold();
        if (model_tick_ms == 0)
            return (model_debounce_ms == 0) ? 2 : 4;
        return 2 + (int'(model_debounce_ms) + int'(model_tick_ms) - 1) / int'(model_tick_ms);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rel_bus.valid && rel_bus.ready)
        begin
            if (pending_releases.size() == 0)
            begin
                mismatches++;
                $display("%0t: released_key with nothing expected, expected none actual %0d",
                         $time, rel_bus.released_key);
            end
            else
            begin
                if (rel_bus.released_key !== pending_releases[0])
                begin
                    mismatches++;
                    $display("%0t: released_key mismatch, expected %0d actual %0d",
                             $time, pending_releases[0], rel_bus.released_key);
                end
                void'(pending_releases.pop_front());
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        rel_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rel_bus.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                rel_bus.ready <= 1'b0;
            end
            else
            begin
                rel_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic [KEY_W-1:0] keys);
        int gap;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 19);
            key_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        key_bus.valid <= 1'b1;
        key_bus.key_matrix <= keys;
        @(posedge clk);
        while (!key_bus.ready) @(posedge clk);
        pending_releases.push_back(advance_keypad(keys));
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic press_keys(input logic [KEY_W-1:0] keys, input int count);
        repeat (count) send_tick(keys);
    endtask

    task automatic stop_ticks();
        key_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_releases.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data <= data;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        case (index)
            REG_TICK_PERIOD: model_tick_ms = data;
            REG_DEBOUNCE:    model_debounce_ms = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] tick_ms, input logic [CFG_W-1:0] deb_ms);
        write_reg(REG_TICK_PERIOD, tick_ms);
        write_reg(REG_DEBOUNCE, deb_ms);
    endtask

    task automatic random_keypress();
        logic [KEY_W-1:0] keys;
        logic [KEY_W-1:0] lowest;
        logic [KEY_W-1:0] next_keys;
        int               len;
        if ($urandom_range(0, 1) == 0)
            keys = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
        else
            keys = KEY_W'($urandom_range(1, 16'hFFFF));
        len = ticks_to_hold();
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(1, (len > 1) ? len - 1 : 1);
        else
            len += $urandom_range(0, 6);
        press_keys(keys, len);
        case ($urandom_range(0, 3))
            0: send_tick('0);
            1:
            begin
                send_tick(KEY_W'($urandom_range(0, 16'hFFFF)));
                if ($urandom_range(0, 1) == 0)
                    send_tick('0);
            end
            2:
            begin
                // keep the winning key, add higher ones, then let go
                lowest = keys & (~keys + KEY_W'(1));
                next_keys = keys | (KEY_W'($urandom_range(0, 16'hFFFF))
                                    & ~((lowest << 1) - KEY_W'(1)));
                press_keys(next_keys, $urandom_range(1, 3));
                send_tick('0);
            end
            default:
            begin
                press_keys('0, $urandom_range(1, 3));
            end
        endcase
    endtask

    task automatic random_noise();
        int count;
        count = $urandom_range(1, 5);
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                send_tick('0);
            else
                send_tick(KEY_W'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    task automatic run_random(input int budget);
        int start;
        start = ticks_sent;
        while (ticks_sent - start < budget)
        begin
            if ($urandom_range(0, 9) < 8)
                random_keypress();
            else
                random_noise();
        end
        stop_ticks();
        wait_drained();
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] tick_ms, input logic [CFG_W-1:0] deb_ms,
                             input int budget);
        set_timing(tick_ms, deb_ms);
        run_random(budget);
    endtask

    task automatic test_reset_values();
        send_tick('0);
        press_keys(16'h0001, ticks_to_hold());
        send_tick('0);
        stop_ticks();
        wait_drained();
    endtask

    task automatic test_directed_edges();
        set_timing(10'd1, 10'd0);
        send_tick('0);
        press_keys(16'hFFFF, 3);
        send_tick(16'h8000);
        press_keys(16'h8000, 2);
        send_tick('0);
        // bounce: a different key at the recheck drops back to scanning
        send_tick(16'h0010);
        send_tick(16'h0020);
        send_tick('0);
        press_keys(16'h0100, 2);
        send_tick(16'h0300);
        send_tick(16'h0200);
        send_tick(16'h7FFE);
        send_tick(16'h0002);
        send_tick(16'h0004);
        stop_ticks();
        wait_drained();
    endtask

    task automatic test_register_map();
        set_timing(10'd10, 10'd40);
        write_reg(REG_UNMAPPED, 10'h3FF);
        write_reg(REG_UNMAPPED, 10'h000);
        run_random(150);
    endtask

    task automatic test_timing_extremes();
        run_phase(10'd1000, 10'd1000, 200);
        run_phase(10'h3FF, 10'h3FF, 150);
        run_phase(10'd1, 10'd0, 200);
        run_phase(10'd0, 10'd0, 150);
        run_phase(10'd0, 10'd3, 60);
        run_phase(10'd7, 10'd61, 250);
        run_phase(10'd1, 10'd30, 200);
    endtask

    task automatic test_random_timing();
        repeat (3)
            run_phase(CFG_W'($urandom_range(0, 10'h3FF)), CFG_W'($urandom_range(0, 120)),
                      100);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_phase(10'd3, 10'd17, 200);
    endtask

    initial
    begin
        rst_n = 1'b0;
        key_bus.valid = 1'b0;
        key_bus.key_matrix = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        mismatches = 0;
        ticks_sent = 0;
        cycle_count = 0;
        idle_on = 1'b1;
        model_state = ST_SCANNING;
        model_held = NO_KEY;
        model_accum = '0;
        model_tick_ms = TICK_PERIOD_RESET;
        model_debounce_ms = DEBOUNCE_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_directed_edges();
        test_register_map();
        test_timing_extremes();
        test_random_timing();
        test_steady_stream();

        wait_drained();
        if (pending_releases.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, pending_releases.size());
        end
        if (mismatches == 0)
            $display("matrix_keypad_debounce_release verification clean");
        else
            $display("matrix_keypad_debounce_release verification failed");
        $finish;
    end

endmodule
